/* rtl/fir_filter_q31_macros.svh */
// assertion macros used by the fir filter top level
`ifndef FIR_FILTER_Q31_MACROS_SVH
`define FIR_FILTER_Q31_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define FQ31_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge out of reset
`define FQ31_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fq31_pkg.sv */
// shared constants and types for the q1.31 fir filter
`default_nettype none

package fq31_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 31;
    localparam int TAPS      = 8;
    localparam int NUM_COEF  = 8;
    localparam int DLY_DEPTH = 7;
    localparam int CNT_W     = $clog2(TAPS + 1);
    localparam int APB_AW    = $clog2(NUM_COEF * 4);
    localparam int IDX_W     = $clog2(NUM_COEF);

    typedef logic signed [DATA_W-1:0]   sample_t;
    typedef sample_t     [TAPS-1:0]     tap_vec_t;
    typedef sample_t     [NUM_COEF-1:0] coef_vec_t;
    typedef sample_t     [DLY_DEPTH-1:0] dly_vec_t;
    typedef logic        [CNT_W-1:0]    cnt_t;

    // data handed from one cell to the next
    typedef struct packed {
        logic     vld;
        sample_t  sum;
        sample_t  prod;
        tap_vec_t taps;
    } link_t;

endpackage

`default_nettype wire

/* rtl/fir_filter_q31.sv */
// Q1.31 direct-form FIR filter, top level with systolic cell chain.
// Path: an item accepted at one edge loads into cell 0 at that edge, then moves through the later cells
// and the output register in turn before it shows on m_filtered; a stall holds the chain in place.
// Throughput: one item per cycle while the skid entry is empty; each cell owns one 32x32 multiplier.
// A two-entry output buffer keeps s_ready high while one result waits.
// Reset (synchronous, aresetn low) clears coefficients, fill count, delay line and valids.
`default_nettype none
`include "fir_filter_q31_macros.svh"

module fir_filter_q31
    import fq31_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input item channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic signed [31:0] s_sample,
    input  wire logic              s_block_start,
    // result item channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic signed [31:0]     m_filtered,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    coef_vec_t coef;
    logic      en;
    logic      accept;
    logic      emit;
    cnt_t      fill_reg;
    cnt_t      fill_next;
    dly_vec_t  dly_reg;
    dly_vec_t  dly_next;
    link_t     head;
    link_t     chain [TAPS];
    logic [TAPS-1:0] cell_vld;
    sample_t   result;
    sample_t   out_reg;
    sample_t   out_next;
    sample_t   skid_reg;
    sample_t   skid_next;
    logic      out_vld_reg;
    logic      out_vld_next;
    logic      skid_vld_reg;
    logic      skid_vld_next;

    // coefficient registers
    fq31_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    // chain advances unless the skid entry is occupied
    assign en      = !skid_vld_reg;
    assign s_ready = en;
    assign accept  = s_valid && s_ready;

    // fill count of the current block
    always_comb begin
        fill_next = fill_reg;
        if (s_block_start) begin
            fill_next = CNT_W'(1);
        end else if (fill_reg < CNT_W'(TAPS)) begin
            fill_next = fill_reg + 1'b1;
        end
    end

    assign emit = fill_next >= CNT_W'(TAPS);

    // sample history, newest first
    always_comb begin
        dly_next[0] = s_sample;
        for (int j = 1; j < DLY_DEPTH; j++) begin
            dly_next[j] = dly_reg[j-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            dly_reg  <= '0;
        end else if (accept) begin
            fill_reg <= fill_next;
            dly_reg  <= dly_next;
        end
    end

    // item entering the chain carries all of its taps
    always_comb begin
        head.vld     = accept && emit;
        head.sum     = '0;
        head.prod    = '0;
        head.taps    = '0;
        head.taps[0] = s_sample;
        for (int j = 1; j < TAPS; j++) begin
            head.taps[j] = dly_reg[j-1];
        end
    end

    // row of tap cells
    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        if (k == 0) begin : g_first
            fq31_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .en       (en),
                .coef     (coef[k]),
                .link_in  (head),
                .link_out (chain[k])
            );
        end else begin : g_rest
            fq31_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .en       (en),
                .coef     (coef[k]),
                .link_in  (chain[k-1]),
                .link_out (chain[k])
            );
        end
        assign cell_vld[k] = chain[k].vld;
    end

    // last product joins the sum, wraps modulo 2^32
    assign result = chain[TAPS-1].sum + chain[TAPS-1].prod;

    // output register plus skid entry
    always_comb begin
        out_next      = out_reg;
        skid_next     = skid_reg;
        out_vld_next  = out_vld_reg;
        skid_vld_next = skid_vld_reg;
        if (out_vld_reg && m_ready) begin
            out_vld_next = 1'b0;
        end
        if (skid_vld_reg) begin
            if (m_ready) begin
                out_next      = skid_reg;
                out_vld_next  = 1'b1;
                skid_vld_next = 1'b0;
            end
        end else if (en && chain[TAPS-1].vld) begin
            if (!out_vld_reg || m_ready) begin
                out_next     = result;
                out_vld_next = 1'b1;
            end else begin
                skid_next     = result;
                skid_vld_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid    = out_vld_reg;
    assign m_filtered = out_reg;

    // checks
    `FQ31_ASSERT_NOW(a_skid_needs_out, skid_vld_reg, out_vld_reg, "skid item without output item")
    `FQ31_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= CNT_W'(TAPS), "fill count beyond tap count")
    `FQ31_ASSERT_NEXT(a_block_restart, accept && s_block_start, fill_reg == CNT_W'(1), "no restart")
    `FQ31_ASSERT_NEXT(a_stall_holds, !en, $stable(cell_vld), "cell chain moved while stalled")

endmodule

`default_nettype wire

/* rtl/fq31_regs.sv */
// apb coefficient register file
`default_nettype none

module fq31_regs
    import fq31_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output coef_vec_t              coef
);

    coef_vec_t        coef_reg;
    coef_vec_t        coef_next;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    // word index from byte address
    assign idx   = paddr[APB_AW-1:2];
    assign wr_en = psel && penable && pwrite;

    always_comb begin
        coef_next = coef_reg;
        if (wr_en) begin
            coef_next[idx] = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else begin
            coef_reg <= coef_next;
        end
    end

    // read back and fixed ready
    assign prdata = coef_reg[idx];
    assign pready = 1'b1;
    assign coef   = coef_reg;

endmodule

`default_nettype wire

/* rtl/fq31_cell.sv */
// one systolic tap cell: multiply own tap, add upstream product to running sum
`default_nettype none

module fq31_cell
    import fq31_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    en,
    input  wire sample_t coef,
    input  wire link_t   link_in,
    output link_t        link_out
);

    link_t                     link_reg;
    link_t                     link_next;
    logic signed [2*DATA_W-1:0] full;

    // q1.31 product of this cell's tap, previous product joins the sum
    always_comb begin
        full           = coef * link_in.taps[0];
        link_next.vld  = link_in.vld;
        link_next.sum  = link_in.sum + link_in.prod;
        link_next.prod = full[FRAC_BITS+DATA_W-1:FRAC_BITS];
        link_next.taps = '0;
        for (int j = 0; j < TAPS - 1; j++) begin
            link_next.taps[j] = link_in.taps[j+1];
        end
    end

    // stage register, held while the chain is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg.vld <= 1'b0;
        end else if (en) begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

`default_nettype wire
